// ===== rtl/obsv_pkg.sv =====
// obsv_pkg: types, codes and constant tables of the oriented box support/vertex kernel
// no dependencies; used by obsv_if.sv consumers and oriented_box_support_and_vertex.sv

package obsv_pkg;

  // operation codes
  localparam logic [1:0] OP_SUPPORT = 2'd0;
  localparam logic [1:0] OP_VERTEX  = 2'd1;
  localparam logic [1:0] OP_FACE    = 2'd2;

  // register indexes (byte address bits 3:2)
  localparam int         REG_ADDR_W = 4;
  localparam logic [1:0] REG_HALF_X = 2'd0;
  localparam logic [1:0] REG_HALF_Y = 2'd1;
  localparam logic [1:0] REG_HALF_Z = 2'd2;

  localparam logic [30:0]        HALF_RESET = 31'd65536;
  localparam logic signed [31:0] UNIT       = 32'sd65536;
  localparam logic [2:0]         FACE_MAX   = 3'd5;

  localparam logic signed [48:0] RND14 = 49'sd8192;
  localparam logic signed [52:0] RND13 = 53'sd4096;

  // cyclic axis order for cross products
  localparam int AX_B [3] = '{1, 2, 0};
  localparam int AX_C [3] = '{2, 0, 1};

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  idx;
    logic        zq;
    logic [2:0]  dneg;
    logic        bad;
    logic        zero;
    logic        addp;
    logic [11:0] corners;
  } meta_t;

  typedef struct packed {
    logic [15:0]       w;
    logic [2:0][15:0]  u;
    logic [2:0][31:0]  p;
  } pose_t;

  // corners of faces +x, -x, +y, -y, +z, -z (x faces clockwise, others ccw)
  function automatic logic [11:0] face_corners(input logic [2:0] face);
    logic [11:0] c;
    case (face)
      3'd0:    c = {3'd1, 3'd5, 3'd7, 3'd3};
      3'd1:    c = {3'd0, 3'd2, 3'd6, 3'd4};
      3'd2:    c = {3'd7, 3'd3, 3'd2, 3'd6};
      3'd3:    c = {3'd5, 3'd4, 3'd0, 3'd1};
      3'd4:    c = {3'd4, 3'd5, 3'd7, 3'd6};
      3'd5:    c = {3'd0, 3'd2, 3'd3, 3'd1};
      default: c = 12'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/obsv_if.sv =====
// obsv_in_if / obsv_out_if: valid/ready channels of the oriented box kernel
// standalone; payload fields at their fixed widths

interface obsv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [2:0]         index;
  logic signed [15:0] rot_w;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (
    output valid, op, dir_x, dir_y, dir_z, index, rot_w, rot_x, rot_y, rot_z,
           pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, op, dir_x, dir_y, dir_z, index, rot_w, rot_x, rot_y, rot_z,
           pos_x, pos_y, pos_z,
    output ready
  );
endinterface

interface obsv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [2:0]         corner_a;
  logic [2:0]         corner_b;
  logic [2:0]         corner_c;
  logic [2:0]         corner_d;
  logic               bad_index;

  modport source (
    output valid, out_x, out_y, out_z, corner_a, corner_b, corner_c, corner_d,
           bad_index,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, corner_a, corner_b, corner_c, corner_d,
           bad_index,
    output ready
  );
endinterface

// ===== rtl/oriented_box_support_and_vertex.sv =====
// oriented_box_support_and_vertex: support point, world vertex and face normal of a posed box
// depends on obsv_pkg (types, codes, face table) and obsv_if.sv (channels)

// Nine-stage pipeline: an item can enter every cycle while query.ready is high; the stages
// are the sign-test multiply, add, multiply, corner select, two multiply/round passes of
// the forward rotation and the saturating add. Each stage holds its own valid bit and moves
// whenever the stage after it is empty or moving, so a stalled result only holds back the
// items behind it and query.ready drops only when all nine stages are full. The user must
// write half extents through the APB port only while no item is in flight; the block does
// not enforce this. The pose travels with every item.

module oriented_box_support_and_vertex (
  input  logic                               clk,
  input  logic                               rst,
  obsv_in_if.sink                            query,
  obsv_out_if.source                         result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [obsv_pkg::REG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // configuration registers
  logic [30:0] half [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      half[0] <= obsv_pkg::HALF_RESET;
      half[1] <= obsv_pkg::HALF_RESET;
      half[2] <= obsv_pkg::HALF_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        obsv_pkg::REG_HALF_X: half[0] <= pwdata[30:0];
        obsv_pkg::REG_HALF_Y: half[1] <= pwdata[30:0];
        obsv_pkg::REG_HALF_Z: half[2] <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      obsv_pkg::REG_HALF_X: prdata = {1'b0, half[0]};
      obsv_pkg::REG_HALF_Y: prdata = {1'b0, half[1]};
      obsv_pkg::REG_HALF_Z: prdata = {1'b0, half[2]};
      default:              prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // stage enables
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld, s9_vld;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

  assign en9 = !s9_vld || result.ready;
  assign en8 = !s8_vld || en9;
  assign en7 = !s7_vld || en8;
  assign en6 = !s6_vld || en7;
  assign en5 = !s5_vld || en6;
  assign en4 = !s4_vld || en5;
  assign en3 = !s3_vld || en4;
  assign en2 = !s2_vld || en3;
  assign en1 = !s1_vld || en2;
  assign query.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
      s8_vld <= 1'b0;
      s9_vld <= 1'b0;
    end else begin
      if (en1) s1_vld <= query.valid;
      if (en2) s2_vld <= s1_vld;
      if (en3) s3_vld <= s2_vld;
      if (en4) s4_vld <= s3_vld;
      if (en5) s5_vld <= s4_vld;
      if (en6) s6_vld <= s5_vld;
      if (en7) s7_vld <= s6_vld;
      if (en8) s8_vld <= s7_vld;
      if (en9) s9_vld <= s8_vld;
    end
  end

  // input decode
  logic signed [31:0] d_in  [3];
  logic signed [28:0] vs_in [3];
  logic signed [15:0] u_in  [3];
  logic signed [15:0] w_in;
  obsv_pkg::meta_t    meta_next;
  obsv_pkg::pose_t    pose_next;
  logic               bad_in;

  assign d_in[0] = query.dir_x;
  assign d_in[1] = query.dir_y;
  assign d_in[2] = query.dir_z;
  assign u_in[0] = query.rot_x;
  assign u_in[1] = query.rot_y;
  assign u_in[2] = query.rot_z;
  assign w_in    = query.rot_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vs_in[i] = d_in[i][31:3];
    end
    bad_in = (query.op == obsv_pkg::OP_FACE) && (query.index > obsv_pkg::FACE_MAX);
    meta_next.op      = query.op;
    meta_next.idx     = query.index;
    meta_next.zq      = (w_in == 16'sd0) && (u_in[0] == 16'sd0) && (u_in[1] == 16'sd0)
                        && (u_in[2] == 16'sd0);
    meta_next.dneg    = {d_in[2][31], d_in[1][31], d_in[0][31]};
    meta_next.bad     = bad_in;
    meta_next.zero    = bad_in || !(query.op inside {obsv_pkg::OP_SUPPORT,
                        obsv_pkg::OP_VERTEX, obsv_pkg::OP_FACE});
    meta_next.addp    = query.op != obsv_pkg::OP_FACE;
    meta_next.corners = (query.op == obsv_pkg::OP_FACE) ?
                        obsv_pkg::face_corners(query.index) : 12'd0;
    pose_next.w    = w_in;
    pose_next.u[0] = u_in[0];
    pose_next.u[1] = u_in[1];
    pose_next.u[2] = u_in[2];
    pose_next.p[0] = query.pos_x;
    pose_next.p[1] = query.pos_y;
    pose_next.p[2] = query.pos_z;
  end

  // stage 1: products of the sign test
  obsv_pkg::meta_t    s1_meta;
  obsv_pkg::pose_t    s1_pose;
  logic signed [44:0] s1_puv [3][3];
  logic signed [31:0] s1_ww;
  logic signed [31:0] s1_uu [3];
  logic signed [28:0] s1_vs [3];

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_meta <= meta_next;
      s1_pose <= pose_next;
      s1_ww   <= 32'(w_in) * 32'(w_in);
      for (int i = 0; i < 3; i++) begin
        s1_uu[i] <= 32'(u_in[i]) * 32'(u_in[i]);
        s1_vs[i] <= vs_in[i];
        for (int j = 0; j < 3; j++) begin
          s1_puv[i][j] <= 45'(u_in[i]) * 45'(vs_in[j]);
        end
      end
    end
  end

  // stage 2: dot, cross and norm difference
  obsv_pkg::meta_t    s2_meta;
  obsv_pkg::pose_t    s2_pose;
  logic signed [46:0] s2_dot;
  logic signed [45:0] s2_cr [3];
  logic signed [33:0] s2_sq;
  logic signed [28:0] s2_vs [3];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_meta <= s1_meta;
      s2_pose <= s1_pose;
      s2_dot  <= 47'(s1_puv[0][0]) + 47'(s1_puv[1][1]) + 47'(s1_puv[2][2]);
      s2_sq   <= 34'(s1_ww) - 34'(s1_uu[0]) - 34'(s1_uu[1]) - 34'(s1_uu[2]);
      for (int i = 0; i < 3; i++) begin
        s2_cr[i] <= 46'(s1_puv[obsv_pkg::AX_B[i]][obsv_pkg::AX_C[i]])
                  - 46'(s1_puv[obsv_pkg::AX_C[i]][obsv_pkg::AX_B[i]]);
        s2_vs[i] <= s1_vs[i];
      end
    end
  end

  // stage 3: sandwich terms
  obsv_pkg::meta_t    s3_meta;
  obsv_pkg::pose_t    s3_pose;
  logic signed [62:0] s3_ta [3];
  logic signed [62:0] s3_tb [3];
  logic signed [61:0] s3_tc [3];

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_meta <= s2_meta;
      s3_pose <= s2_pose;
      for (int i = 0; i < 3; i++) begin
        s3_ta[i] <= 63'(s2_sq) * 63'(s2_vs[i]);
        s3_tb[i] <= 63'(s2_dot) * 63'($signed(s2_pose.u[i]));
        s3_tc[i] <= 62'(s2_cr[i]) * 62'($signed(s2_pose.w));
      end
    end
  end

  // stage 4: sign and local corner or normal
  obsv_pkg::meta_t    s4_meta;
  obsv_pkg::pose_t    s4_pose;
  logic signed [31:0] s4_loc [3];
  logic signed [63:0] sgn [3];
  logic signed [31:0] hpos [3];
  logic signed [31:0] loc_next [3];
  logic               neg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn[i]  = 64'(s3_ta[i]) + (64'(s3_tb[i]) <<< 1) - (64'(s3_tc[i]) <<< 1);
      hpos[i] = $signed({1'b0, half[i]});
      neg[i]  = s3_meta.zq ? s3_meta.dneg[i] : sgn[i][63];
      case (s3_meta.op)
        obsv_pkg::OP_SUPPORT: loc_next[i] = neg[i] ? -hpos[i] : hpos[i];
        obsv_pkg::OP_VERTEX:  loc_next[i] = s3_meta.idx[i] ? hpos[i] : -hpos[i];
        obsv_pkg::OP_FACE: begin
          if (s3_meta.idx[2:1] == 2'(i)) begin
            loc_next[i] = s3_meta.idx[0] ? -obsv_pkg::UNIT : obsv_pkg::UNIT;
          end else begin
            loc_next[i] = 32'sd0;
          end
        end
        default: loc_next[i] = 32'sd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_meta <= s3_meta;
      s4_pose <= s3_pose;
      for (int i = 0; i < 3; i++) begin
        s4_loc[i] <= loc_next[i];
      end
    end
  end

  // stage 5: first cross product of the rotation
  obsv_pkg::meta_t    s5_meta;
  obsv_pkg::pose_t    s5_pose;
  logic signed [31:0] s5_loc [3];
  logic signed [47:0] s5_pa [3];
  logic signed [47:0] s5_pb [3];

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_meta <= s4_meta;
      s5_pose <= s4_pose;
      for (int i = 0; i < 3; i++) begin
        s5_loc[i] <= s4_loc[i];
        s5_pa[i]  <= 48'($signed(s4_pose.u[obsv_pkg::AX_B[i]])) * 48'(s4_loc[obsv_pkg::AX_C[i]]);
        s5_pb[i]  <= 48'($signed(s4_pose.u[obsv_pkg::AX_C[i]])) * 48'(s4_loc[obsv_pkg::AX_B[i]]);
      end
    end
  end

  // stage 6: round cross product to Q16.16
  obsv_pkg::meta_t    s6_meta;
  obsv_pkg::pose_t    s6_pose;
  logic signed [31:0] s6_loc [3];
  logic signed [34:0] s6_c [3];
  logic signed [48:0] dc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dc[i] = 49'(s5_pa[i]) - 49'(s5_pb[i]) + obsv_pkg::RND14;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_meta <= s5_meta;
      s6_pose <= s5_pose;
      for (int i = 0; i < 3; i++) begin
        s6_loc[i] <= s5_loc[i];
        s6_c[i]   <= 35'(dc[i] >>> 14);
      end
    end
  end

  // stage 7: w*c and u x c
  obsv_pkg::meta_t    s7_meta;
  obsv_pkg::pose_t    s7_pose;
  logic signed [31:0] s7_loc [3];
  logic signed [50:0] s7_wc [3];
  logic signed [50:0] s7_ca [3];
  logic signed [50:0] s7_cb [3];

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_meta <= s6_meta;
      s7_pose <= s6_pose;
      for (int i = 0; i < 3; i++) begin
        s7_loc[i] <= s6_loc[i];
        s7_wc[i]  <= 51'($signed(s6_pose.w)) * 51'(s6_c[i]);
        s7_ca[i]  <= 51'($signed(s6_pose.u[obsv_pkg::AX_B[i]])) * 51'(s6_c[obsv_pkg::AX_C[i]]);
        s7_cb[i]  <= 51'($signed(s6_pose.u[obsv_pkg::AX_C[i]])) * 51'(s6_c[obsv_pkg::AX_B[i]]);
      end
    end
  end

  // stage 8: doubled rotation term rounded to Q16.16
  obsv_pkg::meta_t    s8_meta;
  obsv_pkg::pose_t    s8_pose;
  logic signed [31:0] s8_loc [3];
  logic signed [39:0] s8_r [3];
  logic signed [52:0] rs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = 53'(s7_wc[i]) + 53'(s7_ca[i]) - 53'(s7_cb[i]) + obsv_pkg::RND13;
    end
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      s8_meta <= s7_meta;
      s8_pose <= s7_pose;
      for (int i = 0; i < 3; i++) begin
        s8_loc[i] <= s7_loc[i];
        s8_r[i]   <= 40'(rs[i] >>> 13);
      end
    end
  end

  // stage 9: position add (skipped for faces), saturation or zeroing, output register
  logic signed [41:0] tot [3];
  logic signed [31:0] sat_next [3];
  logic signed [31:0] s9_out [3];
  logic [11:0]        s9_corners;
  logic               s9_bad;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = 42'(s8_loc[i]) + 42'(s8_r[i])
             + (s8_meta.addp ? 42'($signed(s8_pose.p[i])) : 42'sd0);
      if (s8_meta.zero) begin
        sat_next[i] = 32'sd0;
      end else if (tot[i] > 42'sd2147483647) begin
        sat_next[i] = 32'sh7fffffff;
      end else if (tot[i] < -42'sd2147483648) begin
        sat_next[i] = 32'sh80000000;
      end else begin
        sat_next[i] = 32'(tot[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en9) begin
      for (int i = 0; i < 3; i++) begin
        s9_out[i] <= sat_next[i];
      end
      s9_corners <= s8_meta.corners;
      s9_bad     <= s8_meta.bad;
    end
  end

  assign result.valid     = s9_vld;
  assign result.out_x     = s9_out[0];
  assign result.out_y     = s9_out[1];
  assign result.out_z     = s9_out[2];
  assign result.corner_a  = s9_corners[11:9];
  assign result.corner_b  = s9_corners[8:6];
  assign result.corner_c  = s9_corners[5:3];
  assign result.corner_d  = s9_corners[2:0];
  assign result.bad_index = s9_bad;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench of oriented_box_support_and_vertex (support, vertex, face queries)
// depends on obsv_pkg, obsv_in_if / obsv_out_if and the block itself; a directed table, then
// random phases over several half-extent settings, checked against a local fixed-point model

module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic signed [31:0] U_ONE = obsv_pkg::UNIT;
  localparam longint L_MAX = 64'sh000000007fffffff;
  localparam longint L_MIN = -64'sh0000000080000000;
  localparam logic signed [15:0] Q_ONE = 16'sd16384;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_LEN = 80;
  localparam int DRAIN = 20;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [2:0]         corner_a;
    logic [2:0]         corner_b;
    logic [2:0]         corner_c;
    logic [2:0]         corner_d;
    logic               bad_index;
  } box_res_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [2:0]         index;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               has_want;
    box_res_t           want;
  } box_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [obsv_pkg::REG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  obsv_in_if  query_bus ();
  obsv_out_if result_bus ();

  oriented_box_support_and_vertex dut (
    .clk     (clk),
    .rst     (rst),
    .query   (query_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [30:0] ext_x = obsv_pkg::HALF_RESET;
  logic [30:0] ext_y = obsv_pkg::HALF_RESET;
  logic [30:0] ext_z = obsv_pkg::HALF_RESET;
  box_item_t   cur_item;
  box_res_t    owed_points [$];
  box_item_t   table_rows [$];
  int          n_fail = 0;
  int          reg_fail = 0;
  int          cycles = 0;
  int          hold_seq = 0;
  bit          calm = 1'b0;

  // fixed-point model of one query under the current half extents
  function automatic box_res_t box_geometry(input box_item_t it);
    longint w, dt, s2, acc;
    longint u[3], d[3], p[3], ext[3], loc[3], vs[3], cr[3], sg[3], c[3], cc[3];
    logic signed [31:0] o[3];
    box_res_t r;
    bit zq, addp;
    r = '0;
    addp = 1'b1;
    w = $signed(it.rot_w);
    u[0] = $signed(it.rot_x);
    u[1] = $signed(it.rot_y);
    u[2] = $signed(it.rot_z);
    d[0] = $signed(it.dir_x);
    d[1] = $signed(it.dir_y);
    d[2] = $signed(it.dir_z);
    p[0] = $signed(it.pos_x);
    p[1] = $signed(it.pos_y);
    p[2] = $signed(it.pos_z);
    ext[0] = longint'(ext_x);
    ext[1] = longint'(ext_y);
    ext[2] = longint'(ext_z);
    case (it.op)
      obsv_pkg::OP_SUPPORT: begin
        zq = (w == 0 && u[0] == 0 && u[1] == 0 && u[2] == 0);
        for (int i = 0; i < 3; i++) vs[i] = d[i] >>> 3;
        dt = u[0] * vs[0] + u[1] * vs[1] + u[2] * vs[2];
        s2 = w * w - (u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
        cr[0] = u[1] * vs[2] - u[2] * vs[1];
        cr[1] = u[2] * vs[0] - u[0] * vs[2];
        cr[2] = u[0] * vs[1] - u[1] * vs[0];
        for (int i = 0; i < 3; i++) begin
          sg[i] = zq ? d[i] : s2 * vs[i] + 2 * dt * u[i] - 2 * w * cr[i];
          loc[i] = (sg[i] >= 0) ? ext[i] : -ext[i];
        end
      end
      obsv_pkg::OP_VERTEX: begin
        for (int i = 0; i < 3; i++) loc[i] = it.index[i] ? ext[i] : -ext[i];
      end
      obsv_pkg::OP_FACE: begin
        if (it.index > obsv_pkg::FACE_MAX) begin
          r.bad_index = 1'b1;
          return r;
        end
        for (int i = 0; i < 3; i++) loc[i] = 0;
        loc[it.index[2:1]] = it.index[0] ? -longint'(U_ONE) : longint'(U_ONE);
        case (it.index)
          3'd0: {r.corner_a, r.corner_b, r.corner_c, r.corner_d} = {3'd1, 3'd5, 3'd7, 3'd3};
          3'd1: {r.corner_a, r.corner_b, r.corner_c, r.corner_d} = {3'd0, 3'd2, 3'd6, 3'd4};
          3'd2: {r.corner_a, r.corner_b, r.corner_c, r.corner_d} = {3'd7, 3'd3, 3'd2, 3'd6};
          3'd3: {r.corner_a, r.corner_b, r.corner_c, r.corner_d} = {3'd5, 3'd4, 3'd0, 3'd1};
          3'd4: {r.corner_a, r.corner_b, r.corner_c, r.corner_d} = {3'd4, 3'd5, 3'd7, 3'd6};
          default: {r.corner_a, r.corner_b, r.corner_c, r.corner_d} = {3'd0, 3'd2, 3'd3, 3'd1};
        endcase
        addp = 1'b0;
      end
      default: return r;
    endcase
    // unnormalized forward rotation, round half up at each narrowing
    c[0] = (u[1] * loc[2] - u[2] * loc[1] + 8192) >>> 14;
    c[1] = (u[2] * loc[0] - u[0] * loc[2] + 8192) >>> 14;
    c[2] = (u[0] * loc[1] - u[1] * loc[0] + 8192) >>> 14;
    cc[0] = u[1] * c[2] - u[2] * c[1];
    cc[1] = u[2] * c[0] - u[0] * c[2];
    cc[2] = u[0] * c[1] - u[1] * c[0];
    for (int i = 0; i < 3; i++) begin
      acc = loc[i] + ((w * c[i] + cc[i] + 4096) >>> 13) + (addp ? p[i] : 64'sd0);
      o[i] = (acc > L_MAX) ? S_MAX : (acc < L_MIN) ? S_MIN : acc[31:0];
    end
    r.out_x = o[0];
    r.out_y = o[1];
    r.out_z = o[2];
    return r;
  endfunction

  function automatic box_item_t mk_row(input logic [1:0] op, input logic signed [31:0] dx,
                                       input logic signed [31:0] dy, input logic signed [31:0] dz,
                                       input logic [2:0] idx, input logic signed [15:0] qw,
                                       input logic signed [15:0] qx, input logic signed [15:0] qy,
                                       input logic signed [15:0] qz, input logic signed [31:0] px,
                                       input logic signed [31:0] py, input logic signed [31:0] pz);
    box_item_t it;
    it = '0;
    it.op = op;
    it.dir_x = dx;
    it.dir_y = dy;
    it.dir_z = dz;
    it.index = idx;
    it.rot_w = qw;
    it.rot_x = qx;
    it.rot_y = qy;
    it.rot_z = qz;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    return it;
  endfunction

  function automatic box_item_t with_want(input box_item_t it, input logic signed [31:0] x,
                                          input logic signed [31:0] y, input logic signed [31:0] z,
                                          input logic [11:0] corners, input logic bad);
    box_item_t r;
    r = it;
    r.has_want = 1'b1;
    r.want.out_x = x;
    r.want.out_y = y;
    r.want.out_z = z;
    {r.want.corner_a, r.want.corner_b, r.want.corner_c, r.want.corner_d} = corners;
    r.want.bad_index = bad;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coord(input int near_bits);
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return 32'sd0;
      1: return int'($urandom_range(0, 15)) - 8;
      2: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      3, 4: return $urandom;
      default: return int'($urandom_range(0, (1 << near_bits) - 1)) - (1 << (near_bits - 1));
    endcase
  endfunction

  function automatic box_item_t rand_query();
    box_item_t it;
    int sel;
    it = '0;
    sel = $urandom_range(0, 15);
    it.op = (sel < 5) ? obsv_pkg::OP_SUPPORT : (sel < 10) ? obsv_pkg::OP_VERTEX :
            (sel < 15) ? obsv_pkg::OP_FACE : OP_UNUSED;
    it.index = 3'($urandom_range(0, 7));
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      it.rot_w = 16'sd0;
    end else if (sel == 1) begin
      it.rot_w = Q_ONE;
    end else if (sel < 4) begin
      {it.rot_w, it.rot_x, it.rot_y, it.rot_z} = {$urandom, $urandom};
    end else begin
      it.rot_w = 16'(int'($urandom_range(0, 32768)) - 16384);
      it.rot_x = 16'(int'($urandom_range(0, 32768)) - 16384);
      it.rot_y = 16'(int'($urandom_range(0, 32768)) - 16384);
      it.rot_z = 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    it.dir_x = rand_coord(20);
    it.dir_y = rand_coord(20);
    it.dir_z = rand_coord(20);
    it.pos_x = rand_coord(24);
    it.pos_y = rand_coord(24);
    it.pos_z = rand_coord(24);
    return it;
  endfunction

  task automatic push_item(input box_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      query_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_bus.valid <= 1'b1;
    query_bus.op    <= it.op;
    query_bus.dir_x <= it.dir_x;
    query_bus.dir_y <= it.dir_y;
    query_bus.dir_z <= it.dir_z;
    query_bus.index <= it.index;
    query_bus.rot_w <= it.rot_w;
    query_bus.rot_x <= it.rot_x;
    query_bus.rot_y <= it.rot_y;
    query_bus.rot_z <= it.rot_z;
    query_bus.pos_x <= it.pos_x;
    query_bus.pos_y <= it.pos_y;
    query_bus.pos_z <= it.pos_z;
    cur_item        <= it;
    do @(posedge clk); while (!query_bus.ready);
  endtask

  // stop offering, let every owed result come back, then a few quiet cycles
  task automatic drain_idle();
    query_bus.valid <= 1'b0;
    @(posedge clk);
    wait (owed_points.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [30:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== {1'b0, want}) begin
      reg_fail++;
      if (reg_fail <= 10)
        $display("register %0d reads %h, expected %h", idx, got, {1'b0, want});
    end
  endtask

  task automatic set_half(input logic [1:0] idx, input logic [31:0] val);
    apb_write(idx, val);
    case (idx)
      obsv_pkg::REG_HALF_X: ext_x = val[30:0];
      obsv_pkg::REG_HALF_Y: ext_y = val[30:0];
      default:              ext_z = val[30:0];
    endcase
    check_reg(idx, val[30:0]);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("oriented_box_support_and_vertex verification failed");
      $finish;
    end
  end

  // scoreboard: predict on each query transfer, compare on each result transfer
  always @(posedge clk) begin : scoreboard
    box_res_t got, want;
    if (!rst) begin
      if (query_bus.valid && query_bus.ready)
        owed_points.push_back(cur_item.has_want ? cur_item.want : box_geometry(cur_item));
      if (result_bus.valid && result_bus.ready) begin
        got.out_x     = result_bus.out_x;
        got.out_y     = result_bus.out_y;
        got.out_z     = result_bus.out_z;
        got.corner_a  = result_bus.corner_a;
        got.corner_b  = result_bus.corner_b;
        got.corner_c  = result_bus.corner_c;
        got.corner_d  = result_bus.corner_d;
        got.bad_index = result_bus.bad_index;
        if (owed_points.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("result with nothing pending at cycle %0d", cycles);
        end else begin
          want = owed_points.pop_front();
          if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
              got.out_z !== want.out_z || got.corner_a !== want.corner_a ||
              got.corner_b !== want.corner_b || got.corner_c !== want.corner_c ||
              got.corner_d !== want.corner_d || got.bad_index !== want.bad_index) begin
            n_fail++;
            if (n_fail <= 10)
              $display("cycle %0d: got %h %h %h c %0d%0d%0d%0d b %b, want %h %h %h c %0d%0d%0d%0d b %b",
                       cycles, got.out_x, got.out_y, got.out_z, got.corner_a, got.corner_b,
                       got.corner_c, got.corner_d, got.bad_index, want.out_x, want.out_y,
                       want.out_z, want.corner_a, want.corner_b, want.corner_c,
                       want.corner_d, want.bad_index);
          end
        end
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_side
    int stall, hold_left, hold_seen;
    logic xfer;
    stall = 0;
    hold_left = 0;
    hold_seen = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      xfer = result_bus.valid && result_bus.ready;
      if (rst) begin
        result_bus.ready <= 1'b0;
      end else if (hold_seq != hold_seen || hold_left > 0) begin
        if (hold_seq != hold_seen) begin
          hold_seen = hold_seq;
          hold_left = HOLD_LEN;
        end
        hold_left--;
        result_bus.ready <= (hold_left == 0);
      end else if (xfer) begin
        stall = calm ? 0 : $urandom_range(0, 5);
        result_bus.ready <= (stall == 0);
      end else if (stall > 0) begin
        stall--;
        result_bus.ready <= (stall == 0);
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : query_side
    box_item_t id_row;
    int k, ph;
    query_bus.valid <= 1'b0;
    query_bus.op    <= obsv_pkg::OP_SUPPORT;
    query_bus.dir_x <= '0;
    query_bus.dir_y <= '0;
    query_bus.dir_z <= '0;
    query_bus.index <= '0;
    query_bus.rot_w <= '0;
    query_bus.rot_x <= '0;
    query_bus.rot_y <= '0;
    query_bus.rot_z <= '0;
    query_bus.pos_x <= '0;
    query_bus.pos_y <= '0;
    query_bus.pos_z <= '0;
    cur_item        <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(obsv_pkg::REG_HALF_X, obsv_pkg::HALF_RESET);
    check_reg(obsv_pkg::REG_HALF_Y, obsv_pkg::HALF_RESET);
    check_reg(obsv_pkg::REG_HALF_Z, obsv_pkg::HALF_RESET);

    // directed table at reset extents; identity and zero poses have obvious answers
    id_row = mk_row(obsv_pkg::OP_SUPPORT, 1, -1, 0, 0, Q_ONE, 0, 0, 0, 0, 0, 0);
    table_rows.push_back(with_want(id_row, U_ONE, -U_ONE, U_ONE, 12'd0, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_SUPPORT, -8, 0, 7, 0, 0, 0, 0, 0,
                                          100, 200, 300),
                                   -U_ONE + 100, U_ONE + 200, U_ONE + 300, 12'd0, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_SUPPORT, -1, -1, -1, 0, Q_ONE, 0, 0, 0,
                                          0, 0, 0),
                                   -U_ONE, -U_ONE, -U_ONE, 12'd0, 1'b0));
    table_rows.push_back(mk_row(obsv_pkg::OP_SUPPORT, S_MIN, S_MAX, S_MIN, 7, -16'sd32768,
                                -16'sd32768, -16'sd32768, -16'sd32768, S_MAX, S_MIN, 0));
    table_rows.push_back(mk_row(obsv_pkg::OP_SUPPORT, S_MAX, S_MIN, S_MAX, 0, 16'sd32767,
                                16'sd32767, 16'sd32767, 16'sd32767, 0, 0, 0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_VERTEX, 0, 0, 0, 0, Q_ONE, 0, 0, 0,
                                          0, 0, 0),
                                   -U_ONE, -U_ONE, -U_ONE, 12'd0, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_VERTEX, 0, 0, 0, 3, Q_ONE, 0, 0, 0,
                                          0, 0, 0),
                                   U_ONE, U_ONE, -U_ONE, 12'd0, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_VERTEX, 0, 0, 0, 5, Q_ONE, 0, 0, 0,
                                          0, 0, 0),
                                   U_ONE, -U_ONE, U_ONE, 12'd0, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_VERTEX, 0, 0, 0, 7, Q_ONE, 0, 0, 0,
                                          S_MAX, S_MAX, S_MAX),
                                   S_MAX, S_MAX, S_MAX, 12'd0, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_VERTEX, 0, 0, 0, 0, Q_ONE, 0, 0, 0,
                                          S_MIN, S_MIN, S_MIN),
                                   S_MIN, S_MIN, S_MIN, 12'd0, 1'b0));
    table_rows.push_back(mk_row(obsv_pkg::OP_VERTEX, 0, 0, 0, 1, 16'sd11585, 0, 0, 16'sd11585,
                                1, 2, 3));
    table_rows.push_back(mk_row(obsv_pkg::OP_VERTEX, S_MAX, S_MAX, S_MAX, 2, -16'sd32768,
                                16'sd32767, -16'sd32768, 16'sd32767, S_MIN, S_MAX, S_MIN));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_VERTEX, 0, 0, 0, 6, 0, 0, 0, 0,
                                          -5, 7, 0),
                                   -U_ONE - 5, U_ONE + 7, U_ONE, 12'd0, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 0, Q_ONE, 0, 0, 0,
                                          1000, 1000, 1000),
                                   U_ONE, 0, 0, {3'd1, 3'd5, 3'd7, 3'd3}, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 1, Q_ONE, 0, 0, 0,
                                          1000, 1000, 1000),
                                   -U_ONE, 0, 0, {3'd0, 3'd2, 3'd6, 3'd4}, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 2, Q_ONE, 0, 0, 0,
                                          S_MAX, 0, 0),
                                   0, U_ONE, 0, {3'd7, 3'd3, 3'd2, 3'd6}, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 3, Q_ONE, 0, 0, 0,
                                          0, S_MIN, 0),
                                   0, -U_ONE, 0, {3'd5, 3'd4, 3'd0, 3'd1}, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 4, Q_ONE, 0, 0, 0,
                                          0, 0, 0),
                                   0, 0, U_ONE, {3'd4, 3'd5, 3'd7, 3'd6}, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 5, Q_ONE, 0, 0, 0,
                                          0, 0, 0),
                                   0, 0, -U_ONE, {3'd0, 3'd2, 3'd3, 3'd1}, 1'b0));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, 1, 2, 3, 6, Q_ONE, 0, 0, 0,
                                          4, 5, 6),
                                   0, 0, 0, 12'd0, 1'b1));
    table_rows.push_back(with_want(mk_row(obsv_pkg::OP_FACE, S_MIN, 0, S_MAX, 7, 16'sd3000,
                                          -16'sd200, 16'sd9000, 16'sd77, S_MAX, S_MIN, 1),
                                   0, 0, 0, 12'd0, 1'b1));
    table_rows.push_back(with_want(mk_row(OP_UNUSED, S_MAX, S_MAX, S_MAX, 7, Q_ONE, 16'sd5, 0, 0,
                                          S_MAX, S_MAX, S_MAX),
                                   0, 0, 0, 12'd0, 1'b0));
    table_rows.push_back(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 2, 0, Q_ONE, 0, 0, 0, 0, 0));
    table_rows.push_back(mk_row(obsv_pkg::OP_FACE, 0, 0, 0, 4, 16'sd32767, -16'sd32768,
                                16'sd32767, -16'sd32768, 0, 0, 0));
    foreach (table_rows[i]) push_item(table_rows[i]);
    drain_idle();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          set_half(obsv_pkg::REG_HALF_X, 32'hffffffff);
          set_half(obsv_pkg::REG_HALF_Y, 32'hffffffff);
          set_half(obsv_pkg::REG_HALF_Z, 32'h7fffffff);
          apb_write(REG_SPARE, $urandom);
        end
        1: begin
          set_half(obsv_pkg::REG_HALF_X, 32'd0);
          set_half(obsv_pkg::REG_HALF_Y, 32'd0);
          set_half(obsv_pkg::REG_HALF_Z, 32'd0);
        end
        2: begin
          set_half(obsv_pkg::REG_HALF_X, $urandom_range(0, 32'h00040000));
          set_half(obsv_pkg::REG_HALF_Y, $urandom_range(0, 32'h00040000));
          set_half(obsv_pkg::REG_HALF_Z, $urandom_range(0, 32'h00040000));
        end
        3: begin
          set_half(obsv_pkg::REG_HALF_X, $urandom);
          set_half(obsv_pkg::REG_HALF_Y, $urandom);
          set_half(obsv_pkg::REG_HALF_Z, $urandom);
        end
        default: begin
          set_half(obsv_pkg::REG_HALF_X, 32'h7fffffff);
          set_half(obsv_pkg::REG_HALF_Y, 32'd0);
          set_half(obsv_pkg::REG_HALF_Z, 32'd1);
        end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        calm = (ph == 2 && k >= 20 && k < 80);
        // back pressure burst while queries keep coming
        if (ph == 2 && k == 30) hold_seq++;
        if (k == PHASE_ITEMS / 2) begin
          query_bus.valid <= 1'b0;
          @(posedge clk);
          wait (owed_points.size() == 0);
          @(posedge clk);
        end
        push_item(rand_query());
      end
      calm = 1'b0;
      drain_idle();
    end

    if (n_fail == 0 && reg_fail == 0 && owed_points.size() == 0) begin
      $display("oriented_box_support_and_vertex verification clean");
    end else begin
      $display("oriented_box_support_and_vertex verification failed");
    end
    $finish;
  end

endmodule
